FILE: rtl/core/weighted_order_dfs_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lightest-edge-first walk block.
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ORDER_DFS_ASSERT_SVH
`define WEIGHTED_ORDER_DFS_ASSERT_SVH

// Property checked at each rising edge, ignored while reset is high.
`define WOD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at each rising edge, reset included.
`define WOD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/wod_pkg.sv
// ----------------------------------------------------------------------------
// wod_pkg
// Types and codes shared by the lightest-edge-first walk block.
// ----------------------------------------------------------------------------
package wod_pkg;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_RUN    = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [5:0]         node_a;
      logic [5:0]         node_b;
      logic signed [15:0] weight;
   } req_type;

   typedef struct packed {
      logic [5:0] node;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CMP,
      ST_ADD_WR2,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_PUSH,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic init;
      logic cand;
      logic add_chk;
   } sel_ctrl_type;

endpackage

FILE: rtl/core/weighted_order_dfs.sv
// ----------------------------------------------------------------------------
// weighted_order_dfs
// Depth-first walk over a weighted undirected graph, lightest edge first.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_ready | action, node_a, node_b, weight
//   rsp     | out       | rsp_valid / rsp_ready | node, last
//
// An add steps through ADD_RD, ADD_CMP and ADD_WR2, and a clear runs the sweep
// that writes every matrix entry as absent. The same sweep runs once after
// reset, during which no request is taken.
// A run reads one matrix row per step of the walk (one row per visited or
// backtracked node), through the single read port of the matrix.
// A stalled rsp holds the walk before the next result is loaded; req_ready is
// high only while the block is idle.
// ----------------------------------------------------------------------------
module weighted_order_dfs #(
   parameter int NODES       = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wod_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wod_pkg::rsp_type rsp_data
);

   localparam int NB    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int DEPTH = NODES * NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic signed [32:0] W_HI = 33'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] W_LO = -W_HI - 33'sd1;

   wod_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                clr_cnt_ff;
   logic [NB-1:0]                v_cnt_ff;
   logic [NB:0]                  depth_ff;
   logic [NB-1:0]                stack_ff [NODES];
   logic [NB-1:0]                top_ff;
   logic [NODES-1:0]             visited_ff;
   logic [NB-1:0]                pend_ff;
   logic [NB-1:0]                a_ff;
   logic [NB-1:0]                b_ff;
   logic signed [WEIGHT_BITS-1:0] w_ff;
   logic                         upd_ff;
   logic                         s_vld_ff;
   logic [NB-1:0]                s_v_ff;
   logic                         s_vis_ff;
   logic                         rsp_valid_ff;
   wod_pkg::rsp_type             rsp_ff;

   logic                          req_fire;
   logic                          a_ok;
   logic                          b_ok;
   logic                          out_free;
   logic                          last_v;
   logic signed [32:0]            w_ext;
   logic signed [WEIGHT_BITS-1:0] w_sat;

   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic                          mem_wp;
   logic [AW-1:0]                 mem_raddr;
   logic                          mem_rp;
   logic signed [WEIGHT_BITS-1:0] mem_rw;
   wod_pkg::sel_ctrl_type         sel_ctrl;
   logic                          sel_found;
   logic [NB-1:0]                 sel_best;
   logic                          sel_upd;
   logic                          load_rsp;
   logic                          load_last;

   assign req_fire = req_valid && req_ready;
   assign a_ok     = 32'(req_data.node_a) < NODES;
   assign b_ok     = 32'(req_data.node_b) < NODES;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_v   = v_cnt_ff == NB'(NODES - 1);

   // Saturate the incoming weight into the stored signed range.
   always_comb begin
      w_ext = 33'(req_data.weight);
      if (w_ext > W_HI) begin
         w_sat = WEIGHT_BITS'(W_HI);
      end else if (w_ext < W_LO) begin
         w_sat = WEIGHT_BITS'(W_LO);
      end else begin
         w_sat = WEIGHT_BITS'(w_ext);
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wod_pkg::ST_CLR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) state_in = wod_pkg::ST_IDLE;
         end
         wod_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.action)
                  wod_pkg::ACT_ADD: begin
                     if (a_ok && b_ok) state_in = wod_pkg::ST_ADD_RD;
                  end
                  wod_pkg::ACT_RUN: begin
                     if (a_ok) state_in = wod_pkg::ST_SCAN;
                  end
                  wod_pkg::ACT_CLEAR: state_in = wod_pkg::ST_CLR;
                  default: state_in = wod_pkg::ST_IDLE;
               endcase
            end
         end
         wod_pkg::ST_ADD_RD:  state_in = wod_pkg::ST_ADD_CMP;
         wod_pkg::ST_ADD_CMP: state_in = wod_pkg::ST_ADD_WR2;
         wod_pkg::ST_ADD_WR2: state_in = wod_pkg::ST_IDLE;
         wod_pkg::ST_SCAN: begin
            if (last_v) state_in = wod_pkg::ST_DRAIN;
         end
         wod_pkg::ST_DRAIN: state_in = wod_pkg::ST_DECIDE;
         wod_pkg::ST_DECIDE: begin
            if (sel_found) begin
               state_in = wod_pkg::ST_PUSH;
            end else if (depth_ff == (NB+1)'(1)) begin
               state_in = wod_pkg::ST_FLUSH;
            end else begin
               state_in = wod_pkg::ST_SCAN;
            end
         end
         wod_pkg::ST_PUSH: begin
            if (out_free) state_in = wod_pkg::ST_SCAN;
         end
         wod_pkg::ST_FLUSH: begin
            if (out_free) state_in = wod_pkg::ST_IDLE;
         end
         default: state_in = wod_pkg::ST_CLR;
      endcase
   end

   // Datapath controls decoded from the state.
   always_comb begin
      req_ready = state_ff == wod_pkg::ST_IDLE;
      mem_we    = 1'b0;
      mem_wp    = 1'b1;
      mem_waddr = AW'(a_ff * NODES + b_ff);
      mem_raddr = AW'(top_ff * NODES + v_cnt_ff);
      sel_ctrl  = '0;
      load_rsp  = 1'b0;
      load_last = 1'b0;
      case (state_ff)
         wod_pkg::ST_CLR: begin
            mem_we    = 1'b1;
            mem_wp    = 1'b0;
            mem_waddr = clr_cnt_ff;
         end
         wod_pkg::ST_ADD_RD: begin
            mem_raddr = AW'(a_ff * NODES + b_ff);
         end
         wod_pkg::ST_ADD_CMP: begin
            sel_ctrl.add_chk = 1'b1;
            mem_we           = sel_upd;
         end
         wod_pkg::ST_ADD_WR2: begin
            mem_we    = upd_ff;
            mem_waddr = AW'(b_ff * NODES + a_ff);
         end
         wod_pkg::ST_SCAN: begin
            sel_ctrl.init = v_cnt_ff == '0;
            sel_ctrl.cand = s_vld_ff && mem_rp && !s_vis_ff;
         end
         wod_pkg::ST_DRAIN: begin
            sel_ctrl.cand = s_vld_ff && mem_rp && !s_vis_ff;
         end
         wod_pkg::ST_PUSH: begin
            load_rsp = out_free;
         end
         wod_pkg::ST_FLUSH: begin
            load_rsp  = out_free;
            load_last = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wod_pkg::ST_CLR;
         clr_cnt_ff   <= '0;
         v_cnt_ff     <= '0;
         depth_ff     <= '0;
         visited_ff   <= '0;
         s_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= (state_ff == wod_pkg::ST_CLR) ? clr_cnt_ff + 1'b1 : '0;
         v_cnt_ff   <= (state_ff == wod_pkg::ST_SCAN && !last_v) ? v_cnt_ff + 1'b1 : '0;
         s_vld_ff   <= state_ff == wod_pkg::ST_SCAN;

         if (req_fire) begin
            if (req_data.action == wod_pkg::ACT_RUN) begin
               // A run starts with only its start node marked as visited.
               if (a_ok) begin
                  visited_ff <= NODES'(1) << req_data.node_a;
                  depth_ff   <= (NB+1)'(1);
               end else begin
                  visited_ff <= '0;
                  depth_ff   <= '0;
               end
            end else if (req_data.action == wod_pkg::ACT_CLEAR) begin
               visited_ff <= '0;
               depth_ff   <= '0;
            end
         end

         if (state_ff == wod_pkg::ST_DECIDE && !sel_found) begin
            depth_ff <= depth_ff - 1'b1;
         end

         if (state_ff == wod_pkg::ST_PUSH && out_free) begin
            visited_ff[sel_best] <= 1'b1;
            depth_ff             <= depth_ff + 1'b1;
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed. The top of the walk stack is kept in
   // its own register; a backtrack reads the entry below it.
   always_ff @(posedge clock) begin
      s_v_ff   <= v_cnt_ff;
      s_vis_ff <= visited_ff[v_cnt_ff];
      if (req_fire) begin
         a_ff <= NB'(req_data.node_a);
         b_ff <= NB'(req_data.node_b);
         w_ff <= w_sat;
         if (req_data.action == wod_pkg::ACT_RUN) begin
            stack_ff[0] <= NB'(req_data.node_a);
            top_ff      <= NB'(req_data.node_a);
            pend_ff     <= NB'(req_data.node_a);
         end
      end
      if (state_ff == wod_pkg::ST_ADD_CMP) begin
         upd_ff <= sel_upd;
      end
      if (state_ff == wod_pkg::ST_DECIDE && !sel_found) begin
         top_ff <= stack_ff[NB'(depth_ff - 2'd2)];
      end
      if (state_ff == wod_pkg::ST_PUSH && out_free) begin
         stack_ff[depth_ff[NB-1:0]] <= sel_best;
         top_ff                     <= sel_best;
         pend_ff                    <= sel_best;
      end
      if (load_rsp) begin
         rsp_ff.node <= 6'(pend_ff);
         rsp_ff.last <= load_last;
      end
   end

   wod_adj_mem #(
      .AW    (AW),
      .W     (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_present (mem_wp),
      .wr_weight  (w_ff),
      .rd_addr    (mem_raddr),
      .rd_present (mem_rp),
      .rd_weight  (mem_rw)
   );

   wod_sel #(
      .NB (NB),
      .W  (WEIGHT_BITS)
   ) u_sel (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sel_ctrl),
      .cand_node   (s_v_ff),
      .mem_present (mem_rp),
      .mem_weight  (mem_rw),
      .new_weight  (w_ff),
      .found       (sel_found),
      .best_node   (sel_best),
      .upd         (sel_upd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/wod_adj_mem.sv
// ----------------------------------------------------------------------------
// wod_adj_mem
// Adjacency matrix store: presence flag and weight, one write, one read port.
// ----------------------------------------------------------------------------
module wod_adj_mem #(
   parameter int AW    = 12,
   parameter int W     = 16,
   parameter int DEPTH = 4096
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic                wr_present,
   input  logic signed [W-1:0] wr_weight,
   input  logic [AW-1:0]       rd_addr,
   output logic                rd_present,
   output logic signed [W-1:0] rd_weight
);

   logic [W:0] mem [DEPTH];
   logic [W:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_present, wr_weight};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_present = rd_ff[W];
   assign rd_weight  = $signed(rd_ff[W-1:0]);

endmodule

FILE: rtl/core/wod_sel.sv
// ----------------------------------------------------------------------------
// wod_sel
// Shared signed comparator with the running best-neighbour register.
// ----------------------------------------------------------------------------
module wod_sel #(
   parameter int NB = 6,
   parameter int W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wod_pkg::sel_ctrl_type ctrl,
   input  logic [NB-1:0]         cand_node,
   input  logic                  mem_present,
   input  logic signed [W-1:0]   mem_weight,
   input  logic signed [W-1:0]   new_weight,
   output logic                  found,
   output logic [NB-1:0]         best_node,
   output logic                  upd
);

   logic                found_ff;
   logic [NB-1:0]       best_node_ff;
   logic signed [W-1:0] best_w_ff;
   logic signed [W-1:0] op_a;
   logic signed [W-1:0] op_b;
   logic                lt;

   // One comparator: new against stored when adding, stored against best when scanning.
   always_comb begin
      op_a = ctrl.add_chk ? new_weight : mem_weight;
      op_b = ctrl.add_chk ? mem_weight : best_w_ff;
      lt   = op_a < op_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.init) begin
         found_ff <= 1'b0;
      end else if (ctrl.cand && (!found_ff || lt)) begin
         found_ff     <= 1'b1;
         best_node_ff <= cand_node;
         best_w_ff    <= mem_weight;
      end
   end

   assign found     = found_ff;
   assign best_node = best_node_ff;
   assign upd       = !mem_present || lt;

endmodule

FILE: rtl/core/wod_chk.sv
// ----------------------------------------------------------------------------
// wod_chk
// Port-level checks for the lightest-edge-first walk block.
// ----------------------------------------------------------------------------
`include "weighted_order_dfs_assert.svh"

module wod_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input wod_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wod_pkg::rsp_type rsp_data
);

   `WOD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `WOD_ASSERT(a_walk_busy, clock, reset, rsp_valid && !rsp_data.last |-> !req_ready, "ready mid-walk")
   `WOD_ASSERT(a_clear_busy, clock, reset, req_valid && req_ready && req_data.action == wod_pkg::ACT_CLEAR |=> !req_ready, "clear not busy")
   `WOD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready, "active after reset")

endmodule

bind weighted_order_dfs wod_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
